/* hw/rtl/multi_slab_first_fit_allocator_core_assert.svh */
// Assertion macros used by the allocator engine RTL.
`ifndef MULTI_SLAB_FIRST_FIT_ALLOCATOR_CORE_ASSERT_SVH
`define MULTI_SLAB_FIRST_FIT_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define MFA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define MFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/mfa_pkg.sv */
// Types and constants of the multi-slab first-fit allocator.
package mfa_pkg;

	localparam int DATA_W = 32;
	localparam int CFG_IDX_W = 1;

	localparam logic [1:0] OP_ALLOC  = 2'd0;
	localparam logic [1:0] OP_FREE   = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;
	// unassigned opcode, answered as not found
	localparam logic [1:0] OP_SPARE  = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOSPACE  = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_ZERO     = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_POOL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLAB = 1'b1;

	localparam logic [DATA_W-1:0] SLAB_RESET = 32'd1048576;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_DISP,
		S_A_META,
		S_A_CHK,
		S_A_SCAN,
		S_A_TAIL,
		S_I_RD,
		S_I_WR,
		S_F_SLAB,
		S_F_META,
		S_F_SCAN,
		S_D_RD,
		S_D_WR
	} state_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [DATA_W-1:0] granted_address;
		logic [2:0]        slab_index;
	} result_t;

endpackage

/* hw/rtl/mfa_ram.sv */
// Simple dual-port synchronous RAM, one write port, one registered read port.
module mfa_ram #(
	parameter int WIDTH  = 64,
	parameter int ADDR_W = 9
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/mfa_engine.sv */
// Request sequencer: slab walk, table scan, insert and delete shifts.
`include "multi_slab_first_fit_allocator_core_assert.svh"

module mfa_engine #(
	parameter int MAX_SLABS   = 8,
	parameter int MAX_ENTRIES = 64,
	parameter int SW  = 3,
	parameter int SCW = 4,
	parameter int EW  = 6,
	parameter int CW  = 7
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [1:0]                  opcode,
	input  logic [mfa_pkg::DATA_W-1:0]  request_bytes,
	input  logic [mfa_pkg::DATA_W-1:0]  block_address,
	input  logic                        init_req,
	input  logic [mfa_pkg::DATA_W-1:0]  pool_bytes,
	input  logic [mfa_pkg::DATA_W-1:0]  slab_bytes,
	output logic                        busy,
	output logic                        done,
	output mfa_pkg::result_t            result,
	output logic                        tbl_we,
	output logic [SW+EW-1:0]            tbl_waddr,
	output logic [63:0]                 tbl_wdata,
	output logic [SW+EW-1:0]            tbl_raddr,
	input  logic [63:0]                 tbl_rdata,
	output logic                        meta_we,
	output logic [SW-1:0]               meta_waddr,
	output logic [CW+31:0]              meta_wdata,
	output logic [SW-1:0]               meta_raddr,
	input  logic [CW+31:0]              meta_rdata
);

	localparam int BW = 32 + SCW;

	mfa_pkg::state_t state_q, state_d;

	logic [1:0]        op_q, op_d;
	logic [31:0]       size_q, size_d, addr_q, addr_d;
	logic [SCW-1:0]    s_q, s_d;
	logic [BW-1:0]     base_q, base_d;
	logic [31:0]       len_q, len_d, free_q, free_d, off_q, off_d, elen_q, elen_d;
	logic [CW-1:0]     cnt_q, cnt_d, k_q, k_d, pos_q, pos_d, j_q, j_d;
	logic [33:0]       cur_q, cur_d;
	mfa_pkg::result_t  res_q, res_d;
	logic              done_q, done_d;

	logic              slab_ok, addr_hit, fit, tail_fail, last_k;
	logic [31:0]       rest, len_now, t_off, t_len, m_free;
	logic [CW-1:0]     m_cnt, k_nx;
	logic [BW-1:0]     slab_ext, base_nx;
	logic [33:0]       st_ext, gap, cur_nx;

	assign slab_ext = BW'(slab_bytes);
	assign base_nx  = base_q + slab_ext;
	assign slab_ok  = (s_q < SCW'(MAX_SLABS)) && (slab_bytes != '0)
		&& (base_q < BW'(pool_bytes));
	assign rest     = pool_bytes - base_q[31:0];
	assign len_now  = (rest < slab_bytes) ? rest : slab_bytes;
	assign addr_hit = BW'(addr_q) < base_nx;
	assign m_cnt    = meta_rdata[CW+31:32];
	assign m_free   = meta_rdata[31:0];
	assign t_off    = tbl_rdata[31:0];
	assign t_len    = tbl_rdata[63:32];
	assign st_ext   = {2'b00, t_off};
	assign gap      = st_ext - cur_q;
	assign fit      = (st_ext >= cur_q) && (gap >= {2'b00, size_q});
	assign cur_nx   = st_ext + {2'b00, t_len};
	assign tail_fail = (cur_q + {2'b00, size_q}) > {2'b00, len_q};
	assign k_nx     = k_q + CW'(1);
	assign last_k   = (k_nx == cnt_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mfa_pkg::S_INIT: begin
				if (s_q == SCW'(MAX_SLABS - 1)) state_d = mfa_pkg::S_IDLE;
			end
			mfa_pkg::S_IDLE: begin
				if (start) state_d = mfa_pkg::S_DISP;
			end
			mfa_pkg::S_DISP: begin
				if (op_q == mfa_pkg::OP_ALLOC) begin
					state_d = (size_q == '0) ? mfa_pkg::S_IDLE : mfa_pkg::S_A_META;
				end else if (op_q == mfa_pkg::OP_FREE || op_q == mfa_pkg::OP_LOOKUP) begin
					state_d = mfa_pkg::S_F_SLAB;
				end else begin
					state_d = mfa_pkg::S_IDLE;
				end
			end
			mfa_pkg::S_A_META: begin
				state_d = slab_ok ? mfa_pkg::S_A_CHK : mfa_pkg::S_IDLE;
			end
			mfa_pkg::S_A_CHK: begin
				if (size_q > m_free || m_cnt == CW'(MAX_ENTRIES)) begin
					state_d = mfa_pkg::S_A_META;
				end else begin
					state_d = (m_cnt == '0) ? mfa_pkg::S_A_TAIL : mfa_pkg::S_A_SCAN;
				end
			end
			mfa_pkg::S_A_SCAN: begin
				if (fit) state_d = mfa_pkg::S_I_RD;
				else if (last_k) state_d = mfa_pkg::S_A_TAIL;
			end
			mfa_pkg::S_A_TAIL: begin
				state_d = tail_fail ? mfa_pkg::S_A_META : mfa_pkg::S_I_RD;
			end
			mfa_pkg::S_I_RD: begin
				state_d = (j_q == pos_q) ? mfa_pkg::S_IDLE : mfa_pkg::S_I_WR;
			end
			mfa_pkg::S_I_WR: state_d = mfa_pkg::S_I_RD;
			mfa_pkg::S_F_SLAB: begin
				if (!slab_ok) state_d = mfa_pkg::S_IDLE;
				else if (addr_hit) state_d = mfa_pkg::S_F_META;
			end
			mfa_pkg::S_F_META: begin
				state_d = (m_cnt == '0) ? mfa_pkg::S_IDLE : mfa_pkg::S_F_SCAN;
			end
			mfa_pkg::S_F_SCAN: begin
				if (t_off == off_q) begin
					state_d = (op_q == mfa_pkg::OP_LOOKUP) ? mfa_pkg::S_IDLE : mfa_pkg::S_D_RD;
				end else if (last_k) begin
					state_d = mfa_pkg::S_IDLE;
				end
			end
			mfa_pkg::S_D_RD: begin
				state_d = ((j_q + CW'(1)) == cnt_q) ? mfa_pkg::S_IDLE : mfa_pkg::S_D_WR;
			end
			mfa_pkg::S_D_WR: state_d = mfa_pkg::S_D_RD;
			default: state_d = mfa_pkg::S_IDLE;
		endcase
		if (init_req) state_d = mfa_pkg::S_INIT;
	end

	// datapath and memory controls
	always_comb begin
		op_d = op_q;
		size_d = size_q;
		addr_d = addr_q;
		s_d = s_q;
		base_d = base_q;
		len_d = len_q;
		free_d = free_q;
		off_d = off_q;
		elen_d = elen_q;
		cnt_d = cnt_q;
		k_d = k_q;
		pos_d = pos_q;
		j_d = j_q;
		cur_d = cur_q;
		res_d = res_q;
		done_d = 1'b0;
		tbl_we = 1'b0;
		tbl_waddr = {s_q[SW-1:0], j_q[EW-1:0]};
		tbl_wdata = tbl_rdata;
		tbl_raddr = {s_q[SW-1:0], k_nx[EW-1:0]};
		meta_we = 1'b0;
		meta_waddr = s_q[SW-1:0];
		meta_wdata = {cnt_q, free_q};
		meta_raddr = s_q[SW-1:0];
		unique case (state_q)
			mfa_pkg::S_INIT: begin
				meta_we = 1'b1;
				meta_wdata = {CW'(0), ((slab_bytes != '0) && (base_q < BW'(pool_bytes)))
					? len_now : 32'd0};
				s_d = s_q + SCW'(1);
				base_d = base_nx;
			end
			mfa_pkg::S_IDLE: begin
				if (start) begin
					op_d = opcode;
					size_d = request_bytes;
					addr_d = block_address;
					s_d = '0;
					base_d = '0;
				end
			end
			mfa_pkg::S_DISP: begin
				if (op_q == mfa_pkg::OP_ALLOC) begin
					if (size_q == '0) begin
						done_d = 1'b1;
						res_d = '{mfa_pkg::ST_ZERO, 32'd0, 3'd0};
					end
				end else if (op_q != mfa_pkg::OP_FREE && op_q != mfa_pkg::OP_LOOKUP) begin
					done_d = 1'b1;
					res_d = '{mfa_pkg::ST_NOTFOUND, 32'd0, 3'd0};
				end
			end
			mfa_pkg::S_A_META: begin
				len_d = len_now;
				if (!slab_ok) begin
					done_d = 1'b1;
					res_d = '{mfa_pkg::ST_NOSPACE, 32'd0, 3'd0};
				end
			end
			mfa_pkg::S_A_CHK: begin
				cnt_d = m_cnt;
				free_d = m_free;
				cur_d = '0;
				k_d = '0;
				tbl_raddr = {s_q[SW-1:0], EW'(0)};
				if (size_q > m_free || m_cnt == CW'(MAX_ENTRIES)) begin
					s_d = s_q + SCW'(1);
					base_d = base_nx;
				end
			end
			mfa_pkg::S_A_SCAN: begin
				if (fit) begin
					pos_d = k_q;
					j_d = cnt_q;
				end else begin
					cur_d = cur_nx;
					k_d = k_nx;
				end
			end
			mfa_pkg::S_A_TAIL: begin
				pos_d = cnt_q;
				j_d = cnt_q;
				if (tail_fail) begin
					s_d = s_q + SCW'(1);
					base_d = base_nx;
				end
			end
			mfa_pkg::S_I_RD: begin
				tbl_raddr = {s_q[SW-1:0], EW'(j_q - CW'(1))};
				if (j_q == pos_q) begin
					tbl_we = 1'b1;
					tbl_waddr = {s_q[SW-1:0], pos_q[EW-1:0]};
					tbl_wdata = {size_q, cur_q[31:0]};
					meta_we = 1'b1;
					meta_wdata = {cnt_q + CW'(1), free_q - size_q};
					done_d = 1'b1;
					res_d = '{mfa_pkg::ST_OK, base_q[31:0] + cur_q[31:0], 3'(s_q)};
				end
			end
			mfa_pkg::S_I_WR: begin
				tbl_we = 1'b1;
				j_d = j_q - CW'(1);
			end
			mfa_pkg::S_F_SLAB: begin
				off_d = addr_q - base_q[31:0];
				if (!slab_ok) begin
					done_d = 1'b1;
					res_d = '{mfa_pkg::ST_NOTFOUND, 32'd0, 3'd0};
				end else if (!addr_hit) begin
					s_d = s_q + SCW'(1);
					base_d = base_nx;
				end
			end
			mfa_pkg::S_F_META: begin
				cnt_d = m_cnt;
				free_d = m_free;
				k_d = '0;
				tbl_raddr = {s_q[SW-1:0], EW'(0)};
				if (m_cnt == '0) begin
					done_d = 1'b1;
					res_d = '{mfa_pkg::ST_NOTFOUND, 32'd0, 3'd0};
				end
			end
			mfa_pkg::S_F_SCAN: begin
				if (t_off == off_q) begin
					elen_d = t_len;
					j_d = k_q;
					if (op_q == mfa_pkg::OP_LOOKUP) begin
						done_d = 1'b1;
						res_d = '{mfa_pkg::ST_OK, 32'd0, 3'(s_q)};
					end
				end else begin
					k_d = k_nx;
					if (last_k) begin
						done_d = 1'b1;
						res_d = '{mfa_pkg::ST_NOTFOUND, 32'd0, 3'd0};
					end
				end
			end
			mfa_pkg::S_D_RD: begin
				tbl_raddr = {s_q[SW-1:0], EW'(j_q + CW'(1))};
				if ((j_q + CW'(1)) == cnt_q) begin
					meta_we = 1'b1;
					meta_wdata = {cnt_q - CW'(1), free_q + elen_q};
					done_d = 1'b1;
					res_d = '{mfa_pkg::ST_OK, 32'd0, 3'd0};
				end
			end
			mfa_pkg::S_D_WR: begin
				tbl_we = 1'b1;
				j_d = j_q + CW'(1);
			end
			default: begin
			end
		endcase
		if (init_req) begin
			s_d = '0;
			base_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mfa_pkg::S_INIT;
			s_q <= '0;
			base_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			s_q <= s_d;
			base_q <= base_d;
			done_q <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q <= op_d;
		size_q <= size_d;
		addr_q <= addr_d;
		len_q <= len_d;
		free_q <= free_d;
		off_q <= off_d;
		elen_q <= elen_d;
		cnt_q <= cnt_d;
		k_q <= k_d;
		pos_q <= pos_d;
		j_q <= j_d;
		cur_q <= cur_d;
		res_q <= res_d;
	end

	assign busy = (state_q != mfa_pkg::S_IDLE);
	assign done = done_q;
	assign result = res_q;

	`MFA_ASSERT_NEXT(a_accept_busy, start && !busy && !init_req, busy, "accepted request left block idle")
	`MFA_ASSERT_NOW(a_scan_range, state_q == mfa_pkg::S_A_SCAN || state_q == mfa_pkg::S_F_SCAN, k_q < cnt_q, "scan index past entry count")
	`MFA_ASSERT_NOW(a_ins_order, state_q == mfa_pkg::S_I_RD, j_q >= pos_q && cnt_q < CW'(MAX_ENTRIES), "insert shift out of range")
	`MFA_ASSERT_NOW(a_tbl_write, tbl_we, state_q == mfa_pkg::S_I_RD || state_q == mfa_pkg::S_I_WR || state_q == mfa_pkg::S_D_WR, "table written outside shift")

endmodule

/* hw/rtl/multi_slab_first_fit_allocator_core.sv */
// Top level of the multi-slab first-fit allocator.
// Use: write pool_bytes (index 0) and slab_bytes (index 1) through cfg_we,
// cfg_index and cfg_data while the block is idle; each write empties every
// slab table and resets the free counts. Pulse start with opcode,
// request_bytes and block_address while busy is low to issue a request.
// Exactly one result follows per request, shown for one cycle with done
// high on status, granted_address and slab_index; the receiver cannot stall.
// A lookup or free walks the slabs up to the owning slab, reads its
// counters and scans its table entries; a free then shifts the following
// entries down. An allocate reads and checks the counters of each slab
// visited, scans its table entries, checks the tail when no gap fits and
// shifts the later entries up on insert. One request at a time; the
// per-entry table walk through the single read port sets the rate. Reset
// and every configuration write start a sweep over the MAX_SLABS slabs
// that rebuilds the per-slab counters; busy stays high.
module multi_slab_first_fit_allocator_core #(
	parameter int MAX_SLABS   = 8,
	parameter int MAX_ENTRIES = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mfa_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mfa_pkg::DATA_W-1:0]          cfg_data,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          opcode,
	input  logic [mfa_pkg::DATA_W-1:0]          request_bytes,
	input  logic [mfa_pkg::DATA_W-1:0]          block_address,
	output logic                                done,
	output logic [1:0]                          status,
	output logic [mfa_pkg::DATA_W-1:0]          granted_address,
	output logic [2:0]                          slab_index
);

	localparam int SW  = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
	localparam int SCW = $clog2(MAX_SLABS + 1);
	localparam int EW  = $clog2(MAX_ENTRIES);
	localparam int CW  = $clog2(MAX_ENTRIES + 1);

	logic [mfa_pkg::DATA_W-1:0] pool_q, slab_q;
	mfa_pkg::result_t           res;

	logic              tbl_we, meta_we;
	logic [SW+EW-1:0]  tbl_waddr, tbl_raddr;
	logic [63:0]       tbl_wdata, tbl_rdata;
	logic [SW-1:0]     meta_waddr, meta_raddr;
	logic [CW+31:0]    meta_wdata, meta_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q <= '0;
			slab_q <= mfa_pkg::SLAB_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mfa_pkg::CFG_POOL: pool_q <= cfg_data;
				mfa_pkg::CFG_SLAB: slab_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	mfa_engine #(
		.MAX_SLABS(MAX_SLABS),
		.MAX_ENTRIES(MAX_ENTRIES),
		.SW(SW),
		.SCW(SCW),
		.EW(EW),
		.CW(CW)
	) u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.opcode(opcode),
		.request_bytes(request_bytes),
		.block_address(block_address),
		.init_req(cfg_we),
		.pool_bytes(pool_q),
		.slab_bytes(slab_q),
		.busy(busy),
		.done(done),
		.result(res),
		.tbl_we(tbl_we),
		.tbl_waddr(tbl_waddr),
		.tbl_wdata(tbl_wdata),
		.tbl_raddr(tbl_raddr),
		.tbl_rdata(tbl_rdata),
		.meta_we(meta_we),
		.meta_waddr(meta_waddr),
		.meta_wdata(meta_wdata),
		.meta_raddr(meta_raddr),
		.meta_rdata(meta_rdata)
	);

	mfa_ram #(.WIDTH(64), .ADDR_W(SW + EW)) u_table (
		.clk(clk),
		.we(tbl_we),
		.waddr(tbl_waddr),
		.wdata(tbl_wdata),
		.raddr(tbl_raddr),
		.rdata(tbl_rdata)
	);

	mfa_ram #(.WIDTH(CW + 32), .ADDR_W(SW)) u_meta (
		.clk(clk),
		.we(meta_we),
		.waddr(meta_waddr),
		.wdata(meta_wdata),
		.raddr(meta_raddr),
		.rdata(meta_rdata)
	);

	assign status = res.status;
	assign granted_address = res.granted_address;
	assign slab_index = res.slab_index;

endmodule

/* tb/sv/multi_slab_first_fit_allocator_core_test.sv */
// Self-checking testbench for the multi-slab first-fit allocator core.
`timescale 1ns / 100ps

class alloc_scoreboard;
	mfa_pkg::result_t expected_results[$];
	int mismatches;
	int checked;

	function void note_request(mfa_pkg::result_t exp_res);
		expected_results = {expected_results, exp_res};
	endfunction

	function void check_result(mfa_pkg::result_t got);
		mfa_pkg::result_t exp_res;
		if (expected_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: status %0d addr %h slab %0d",
					got.status, got.granted_address, got.slab_index);
			return;
		end
		exp_res = expected_results.pop_front();
		checked++;
		if (got.status != exp_res.status ||
			got.granted_address != exp_res.granted_address ||
			got.slab_index != exp_res.slab_index) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: exp status %0d addr %h slab %0d, %s %0d addr %h slab %0d",
					exp_res.status, exp_res.granted_address, exp_res.slab_index,
					"got status", got.status, got.granted_address, got.slab_index);
		end
	endfunction

	function int pending();
		return expected_results.size();
	endfunction
endclass

module multi_slab_first_fit_allocator_core_test;

	localparam int NSLAB = 8;
	localparam int NENT = 64;
	localparam int CYCLE_LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [mfa_pkg::CFG_IDX_W-1:0] cfg_index = mfa_pkg::CFG_POOL;
	logic [mfa_pkg::DATA_W-1:0] cfg_data = '0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] opcode = mfa_pkg::OP_ALLOC;
	logic [mfa_pkg::DATA_W-1:0] request_bytes = '0;
	logic [mfa_pkg::DATA_W-1:0] block_address = '0;
	logic done;
	logic [1:0] status;
	logic [mfa_pkg::DATA_W-1:0] granted_address;
	logic [2:0] slab_index;

	multi_slab_first_fit_allocator_core #(.MAX_SLABS(NSLAB), .MAX_ENTRIES(NENT)) i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .start(start), .busy(busy), .opcode(opcode),
		.request_bytes(request_bytes), .block_address(block_address), .done(done),
		.status(status), .granted_address(granted_address), .slab_index(slab_index)
	);

	always #2 clk = ~clk;

	// predictor state
	logic [31:0] pool_sz = 32'd0;
	logic [31:0] slab_sz = mfa_pkg::SLAB_RESET;
	logic [31:0] blk_off [NSLAB][NENT];
	logic [31:0] blk_len [NSLAB][NENT];
	int blk_cnt [NSLAB];
	logic [31:0] slab_free [NSLAB];

	alloc_scoreboard sb = new();
	logic [31:0] live_blocks[$];
	int cycles = 0;
	int sender_idle_pct = 0;
	int requests_sent = 0;
	int grants = 0;

	function automatic int slab_count();
		logic [63:0] n;
		if (slab_sz == 0)
			return 0;
		n = (64'(pool_sz) + 64'(slab_sz) - 1) / 64'(slab_sz);
		return n > NSLAB ? NSLAB : int'(n);
	endfunction

	function automatic logic [31:0] slab_length(int s);
		logic [63:0] rest;
		rest = 64'(pool_sz) - 64'(s) * 64'(slab_sz);
		return rest < 64'(slab_sz) ? rest[31:0] : slab_sz;
	endfunction

	function automatic void rebuild_pool();
		int n;
		n = slab_count();
		for (int i = 0; i < NSLAB; i++) begin
			blk_cnt[i] = 0;
			slab_free[i] = i < n ? slab_length(i) : 32'd0;
		end
	endfunction

	function automatic bit place_in_slab(int s, logic [31:0] sz, output logic [31:0] off);
		logic [63:0] cur;
		logic [63:0] st;
		int pos;
		bit hit;
		cur = 0;
		pos = blk_cnt[s];
		hit = 0;
		off = 0;
		if (sz > slab_free[s] || blk_cnt[s] >= NENT)
			return 0;
		for (int k = 0; k < blk_cnt[s]; k++) begin
			st = 64'(blk_off[s][k]);
			if (st >= cur && st - cur >= 64'(sz)) begin
				pos = k;
				hit = 1;
				break;
			end
			cur = st + 64'(blk_len[s][k]);
		end
		if (!hit && cur + 64'(sz) > 64'(slab_length(s)))
			return 0;
		for (int j = blk_cnt[s]; j > pos; j--) begin
			blk_off[s][j] = blk_off[s][j-1];
			blk_len[s][j] = blk_len[s][j-1];
		end
		blk_off[s][pos] = cur[31:0];
		blk_len[s][pos] = sz;
		blk_cnt[s]++;
		slab_free[s] -= sz;
		off = cur[31:0];
		return 1;
	endfunction

	function automatic bit locate_block(logic [31:0] ad, output int s, output int slot);
		int n;
		logic [63:0] sl;
		logic [63:0] off;
		n = slab_count();
		s = 0;
		slot = 0;
		if (n == 0)
			return 0;
		sl = 64'(ad / slab_sz);
		if (sl >= 64'(n))
			return 0;
		s = int'(sl);
		off = 64'(ad) - sl * 64'(slab_sz);
		for (int k = 0; k < blk_cnt[s]; k++)
			if (64'(blk_off[s][k]) == off) begin
				slot = k;
				return 1;
			end
		return 0;
	endfunction

	function automatic mfa_pkg::result_t predict_result(logic [1:0] op, logic [31:0] sz,
		logic [31:0] ad);
		mfa_pkg::result_t r;
		int s;
		int slot;
		logic [31:0] off;
		logic [63:0] addr64;
		r.status = mfa_pkg::ST_NOTFOUND;
		r.granted_address = '0;
		r.slab_index = '0;
		if (op == mfa_pkg::OP_ALLOC) begin
			if (sz == 0) begin
				r.status = mfa_pkg::ST_ZERO;
			end else begin
				r.status = mfa_pkg::ST_NOSPACE;
				for (s = 0; s < slab_count(); s++)
					if (place_in_slab(s, sz, off)) begin
						addr64 = 64'(s) * 64'(slab_sz) + 64'(off);
						r.status = mfa_pkg::ST_OK;
						r.granted_address = addr64[31:0];
						r.slab_index = 3'(s);
						break;
					end
			end
		end else if (op == mfa_pkg::OP_FREE) begin
			if (locate_block(ad, s, slot)) begin
				slab_free[s] += blk_len[s][slot];
				for (int j = slot; j < blk_cnt[s] - 1; j++) begin
					blk_off[s][j] = blk_off[s][j+1];
					blk_len[s][j] = blk_len[s][j+1];
				end
				blk_cnt[s]--;
				r.status = mfa_pkg::ST_OK;
			end
		end else if (op == mfa_pkg::OP_LOOKUP) begin
			if (locate_block(ad, s, slot)) begin
				r.status = mfa_pkg::ST_OK;
				r.slab_index = 3'(s);
			end
		end
		return r;
	endfunction

	task automatic send_request(logic [1:0] op, logic [31:0] sz, logic [31:0] ad);
		int gap;
		mfa_pkg::result_t r;
		gap = 0;
		while (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct && gap < 40)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		request_bytes <= sz;
		block_address <= ad;
		do @(posedge clk); while (busy);
		r = predict_result(op, sz, ad);
		sb.note_request(r);
		requests_sent++;
		if (op == mfa_pkg::OP_ALLOC && r.status == mfa_pkg::ST_OK) begin
			live_blocks = {live_blocks, r.granted_address};
			grants++;
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(logic [mfa_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == mfa_pkg::CFG_POOL)
			pool_sz = val;
		else
			slab_sz = val;
		rebuild_pool();
		live_blocks.delete();
		repeat (2) @(posedge clk);
	endtask

	task automatic random_request(logic [31:0] size_cap);
		int pick;
		int k;
		logic [31:0] ad;
		pick = $urandom_range(0, 99);
		k = 0;
		if (pick < 50) begin
			if ($urandom_range(0, 19) == 0)
				send_request(mfa_pkg::OP_ALLOC, $urandom(), 32'($urandom()));
			else if ($urandom_range(0, 29) == 0)
				send_request(mfa_pkg::OP_ALLOC, 32'd0, $urandom());
			else
				send_request(mfa_pkg::OP_ALLOC, $urandom_range(1, size_cap), $urandom());
		end else if (pick < 97) begin
			if (live_blocks.size() > 0 && $urandom_range(0, 9) < 8) begin
				k = $urandom_range(0, live_blocks.size() - 1);
				ad = live_blocks[k];
				if ($urandom_range(0, 9) == 0)
					ad = ad + 1;
			end else begin
				ad = $urandom();
			end
			if (pick < 78) begin
				send_request(mfa_pkg::OP_FREE, $urandom(), ad);
				if (live_blocks.size() > 0 && live_blocks[k] == ad)
					live_blocks.delete(k);
			end else begin
				send_request(mfa_pkg::OP_LOOKUP, $urandom(), ad);
			end
		end else begin
			send_request(mfa_pkg::OP_SPARE, $urandom(), $urandom());
		end
	endtask

	always @(posedge clk) begin
		if (done)
			sb.check_result('{status: status, granted_address: granted_address,
				slab_index: slab_index});
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		logic [31:0] pools [7];
		logic [31:0] slabs [7];
		logic [31:0] caps [7];
		logic [31:0] a0;
		logic [31:0] a1;
		rebuild_pool();
		pools = '{32'd4096, 32'd600, 32'd100, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1000,
			32'd70000};
		slabs = '{32'd1024, 32'd64, 32'd7, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd16384};
		caps = '{32'd256, 32'd4, 32'd3, 32'd1, 32'h0FFF_FFFF, 32'd100, 32'd3000};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: empty pool
		send_request(mfa_pkg::OP_ALLOC, 32'd1, 32'd0);
		send_request(mfa_pkg::OP_ALLOC, 32'd0, 32'hFFFF_FFFF);
		send_request(mfa_pkg::OP_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(mfa_pkg::OP_FREE, 32'd0, 32'hFFFF_FFFF);
		send_request(mfa_pkg::OP_LOOKUP, 32'd0, 32'd0);

		write_register(mfa_pkg::CFG_POOL, 32'd4096);
		write_register(mfa_pkg::CFG_SLAB, 32'd1024);
		send_request(mfa_pkg::OP_ALLOC, 32'd1024, 32'd0);
		send_request(mfa_pkg::OP_ALLOC, 32'd1, 32'd0);
		send_request(mfa_pkg::OP_ALLOC, 32'd100, 32'd0);
		send_request(mfa_pkg::OP_ALLOC, 32'd5000, 32'd0);
		send_request(mfa_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
		drain_results();
		a0 = live_blocks[0];
		a1 = live_blocks[1];
		send_request(mfa_pkg::OP_LOOKUP, 32'd0, a1);
		send_request(mfa_pkg::OP_LOOKUP, 32'd0, a1 + 1);
		send_request(mfa_pkg::OP_FREE, 32'd0, a0);
		send_request(mfa_pkg::OP_FREE, 32'd0, a0);
		send_request(mfa_pkg::OP_ALLOC, 32'd512, 32'd0);
		send_request(mfa_pkg::OP_ALLOC, 32'd600, 32'd0);
		send_request(mfa_pkg::OP_LOOKUP, 32'd0, 32'hFFFF_FFFF);
		live_blocks.delete();

		for (int ph = 0; ph < 7; ph++) begin
			sender_idle_pct = ph < 3 ? 38 : (ph < 5 ? 0 : 0);
			if (ph >= 3 && ph < 5)
				sender_idle_pct = 72;
			write_register(mfa_pkg::CFG_SLAB, slabs[ph]);
			write_register(mfa_pkg::CFG_POOL, pools[ph]);
			for (int i = 0; i < 132; i++) begin
				random_request(caps[ph]);
				if (i == 66)
					drain_results();
			end
		end

		drain_results();
		repeat (20) @(posedge clk);
		$display("%0d requests over 8 pool/slab settings incl. zero slab size and %s",
			requests_sent, "32-bit extremes");
		$display("%0d results checked, %0d blocks granted", sb.checked, grants);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
